// File: src/mono_cv_gate_note_priority_top_macros.svh
// Assertion macros shared by the note priority converter RTL.
`ifndef MONO_CV_GATE_NOTE_PRIORITY_TOP_MACROS_SVH
`define MONO_CV_GATE_NOTE_PRIORITY_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mcvg_pkg.sv
// Shared types, codes and constants of the note priority CV/gate converter.
`default_nettype none

package mcvg_pkg;

  localparam int StackDepthDefault = 16;

  localparam int NoteW   = 7;
  localparam int HighW   = 8;
  localparam int StepW   = 16;
  localparam int WinW    = 16;
  localparam int TickW   = 17;
  localparam int PitchW  = 12;
  localparam int OpW     = 2;
  localparam int ProdW   = NoteW + StepW;
  localparam int FracBits = 8;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 8;
  localparam int InUserW  = 2;
  localparam int OutDataW = 16;
  localparam int OutWordW = 1 + PitchW;

  localparam logic [NoteW-1:0]  LowestReset  = 7'd36;
  localparam logic [HighW-1:0]  HighestReset = 8'd91;
  localparam logic              ModeReset    = 1'b0;
  localparam logic [StepW-1:0]  StepsReset   = 16'd18990;
  localparam logic [WinW-1:0]   WindowReset  = 16'd10000;
  localparam logic [TickW-1:0]  TickMax      = '1;
  localparam logic [PitchW-1:0] PitchMax     = '1;
  localparam logic [ProdW-1:0]  RoundHalf    = ProdW'(128);

  typedef enum logic [OpW-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LOWEST  = 3'd0,
    CFG_HIGHEST = 3'd1,
    CFG_MODE    = 3'd2,
    CFG_STEPS   = 3'd3,
    CFG_WINDOW  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_OUT
  } state_t;

  // Control broadcast to every stack cell.
  typedef struct packed {
    logic             load;
    logic             note_on;
    logic             evict;
    logic [NoteW-1:0] offset;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/mcvg_cell.sv
// One slot of the held-note stack with its compare, shift and pick logic.
`default_nettype none

module mcvg_cell
  import mcvg_pkg::*;
#(
  parameter int CountW = 5,
  parameter int Idx    = 0
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [CountW-1:0] count,
  input  wire logic [CountW-1:0] top,
  input  wire logic [CountW-1:0] sel,
  input  wire logic [NoteW-1:0]  upper,
  input  wire logic              found_in,
  output logic                   found_out,
  input  wire logic [NoteW-1:0]  pick_in,
  output logic [NoteW-1:0]       pick_out,
  output logic [NoteW-1:0]       value
);

  logic live;
  logic match;
  logic shift;

  // A slot is live when it lies below the fill count.
  assign live      = CountW'(Idx) < count;
  assign match     = live && (value == ctrl.offset);
  assign found_out = found_in | match;
  // Slots at or above a removed note, or all slots on eviction, take the one above.
  assign shift     = found_out | ctrl.evict;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.note_on && (CountW'(Idx) == top)) begin
        value <= ctrl.offset;
      end else if (shift) begin
        value <= upper;
      end
    end
  end

  assign pick_out = pick_in | ((CountW'(Idx) == sel) ? value : '0);

endmodule

`default_nettype wire

// File: src/mcvg_pitch.sv
// Pitch unit: registered note-by-step product, then rounding and saturation.
`default_nettype none

module mcvg_pitch
  import mcvg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NoteW-1:0]  offset,
  input  wire logic [StepW-1:0]  steps,
  output logic [PitchW-1:0]      code
);

  logic [ProdW-1:0]          prod;
  logic [ProdW-1:0]          rounded_full;
  logic [ProdW-FracBits-1:0] rounded;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ProdW'(offset) * ProdW'(steps);
    end
  end

  // The product stays below 2^23 by more than a half, so adding a half cannot overflow.
  assign rounded_full = prod + RoundHalf;
  assign rounded      = rounded_full[ProdW-1:FracBits];
  assign code = (rounded > (ProdW-FracBits)'(PitchMax)) ? PitchMax : rounded[PitchW-1:0];

endmodule

`default_nettype wire

// File: src/mono_cv_gate_note_priority_top.sv
// Top level of the monophonic note-to-CV/gate converter with last-note priority.
`default_nettype none

// Each input word carries a note-on, note-off or tick, and each one produces
// exactly one output word holding the gate level and 12-bit pitch code that
// stand after it. A word passes through these steps on its way to the output
// register: the stack cells update in the accept cycle, the newest held note
// is picked from the cell chain in the next, the pitch multiplier is
// registered after that and the rounded, saturated code is loaded last. The
// block takes a new word only once the last one is in the output register,
// and a stalled output word holds the whole block in its last step. Held
// notes live in a row of STACK_DEPTH identical cells, each storing one note
// offset; a removal ripples a found flag up the row and every cell above the
// removed note takes the value of its upper neighbour, while a push onto a
// full stack shifts the whole row down and drops the oldest note. Notes
// outside the range from lowest_note up to, but not including, highest_note
// are ignored. In retrigger mode a new note that arrives with notes already
// held and the window elapsed drops the gate until the tick count exceeds retrig_window.
// Configuration must only be written while no word is in flight.

module mono_cv_gate_note_priority_top
  import mcvg_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [6:0] note, rest zero
  input  wire logic [InUserW-1:0]  s_axis_tuser,   // [1:0] operation
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [0] gate, [12:1] pitch, rest zero
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  `include "mono_cv_gate_note_priority_top_macros.svh"

  localparam int CountW = $clog2(STACK_DEPTH + 1);

  // Configuration registers.
  logic [NoteW-1:0] lowest_note;
  logic [HighW-1:0] highest_note;
  logic             trigger_mode;
  logic [StepW-1:0] steps_per_semitone;
  logic [WinW-1:0]  retrig_window;

  // Converter state.
  logic [CountW-1:0] held_count;
  logic [CountW-1:0] held_count_next;
  logic              gate_level;
  logic              gate_level_next;
  logic [PitchW-1:0] pitch_code;
  logic              pulse_pending;
  logic              pulse_pending_next;
  logic [TickW-1:0]  ticks;
  logic [TickW-1:0]  ticks_next;

  // Per-word sequencing.
  state_t            state;
  state_t            state_next;
  logic [NoteW-1:0]  offset_q;
  logic              use_top;
  logic              use_top_next;
  logic              do_pitch;
  logic              do_pitch_next;
  logic [NoteW-1:0]  pitch_src;
  logic [PitchW-1:0] pitch_calc;
  logic [PitchW-1:0] pitch_new;
  logic [OutWordW-1:0] out_word;
  logic              out_load;

  // Input decode.
  logic             acc;
  logic [OpW-1:0]   op;
  logic [NoteW-1:0] note;
  logic [NoteW-1:0] offset;
  logic             in_range;
  logic             is_on;
  logic             is_off;
  logic             full;
  logic             found_any;
  logic [CountW-1:0] top_idx;
  logic [CountW-1:0] sel_idx;
  logic [TickW-1:0] ticks_inc;
  cell_ctrl_t       ctrl;

  logic [STACK_DEPTH:0]  found_chain;
  logic [NoteW-1:0]      pick_chain [STACK_DEPTH+1];
  logic [NoteW-1:0]      cell_value [STACK_DEPTH];

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign op       = s_axis_tuser;
  assign note     = s_axis_tdata[NoteW-1:0];
  assign offset   = note - lowest_note;
  assign in_range = (note >= lowest_note) && ({1'b0, note} < highest_note);
  assign is_on    = in_range && (op == OP_NOTE_ON);
  assign is_off   = in_range && (op == OP_NOTE_OFF);
  assign full     = held_count == CountW'(STACK_DEPTH);

  assign found_chain[0] = 1'b0;
  assign pick_chain[0]  = '0;
  assign found_any      = found_chain[STACK_DEPTH];

  // A repeated note or a full stack leaves the new note one slot below the count.
  assign top_idx = (found_any || full) ? held_count - CountW'(1) : held_count;
  assign sel_idx = held_count - CountW'(1);

  assign ctrl.load    = acc && (is_on || is_off);
  assign ctrl.note_on = is_on;
  assign ctrl.evict   = is_on && !found_any && full;
  assign ctrl.offset  = offset;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [NoteW-1:0] upper;

    if (i == STACK_DEPTH - 1) begin : g_last
      // The top slot has no neighbour; whatever it takes is never read.
      assign upper = offset;
    end else begin : g_inner
      assign upper = cell_value[i+1];
    end

    mcvg_cell #(
      .CountW (CountW),
      .Idx    (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (held_count),
      .top       (top_idx),
      .sel       (sel_idx),
      .upper     (upper),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .pick_in   (pick_chain[i]),
      .pick_out  (pick_chain[i+1]),
      .value     (cell_value[i])
    );
  end

  mcvg_pitch u_pitch (
    .clk    (clk),
    .en     (state == ST_MUL),
    .offset (pitch_src),
    .steps  (steps_per_semitone),
    .code   (pitch_calc)
  );

  assign pitch_new = do_pitch ? pitch_calc : pitch_code;

  // Stack count, gate and retrigger timer for the word being accepted.
  always_comb begin
    held_count_next    = held_count;
    gate_level_next    = gate_level;
    pulse_pending_next = pulse_pending;
    ticks_next         = ticks;
    use_top_next       = 1'b0;
    do_pitch_next      = 1'b0;
    ticks_inc          = (ticks == TickMax) ? ticks : ticks + TickW'(1);
    case (op)
      OP_NOTE_ON: begin
        if (in_range) begin
          do_pitch_next = 1'b1;
          if (!(found_any || full)) begin
            held_count_next = held_count + CountW'(1);
          end
          if (!trigger_mode) begin
            gate_level_next = 1'b1;
          end else begin
            if ((held_count != '0) && (ticks > TickW'(retrig_window))) begin
              pulse_pending_next = 1'b1;
              gate_level_next    = 1'b0;
            end else begin
              gate_level_next = 1'b1;
            end
            ticks_next = '0;
          end
        end
      end
      OP_NOTE_OFF: begin
        if (in_range) begin
          if (found_any) begin
            held_count_next = held_count - CountW'(1);
          end
          if (held_count_next == '0) begin
            gate_level_next    = 1'b0;
            pulse_pending_next = 1'b0;
          end else begin
            use_top_next  = 1'b1;
            do_pitch_next = 1'b1;
          end
        end
      end
      OP_TICK: begin
        ticks_next = ticks_inc;
        if (pulse_pending && (ticks_inc > TickW'(retrig_window))) begin
          gate_level_next    = 1'b1;
          pulse_pending_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_note        <= LowestReset;
      highest_note       <= HighestReset;
      trigger_mode       <= ModeReset;
      steps_per_semitone <= StepsReset;
      retrig_window      <= WindowReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LOWEST:  lowest_note        <= cfg_data[NoteW-1:0];
        CFG_HIGHEST: highest_note       <= cfg_data[HighW-1:0];
        CFG_MODE:    trigger_mode       <= cfg_data[0];
        CFG_STEPS:   steps_per_semitone <= cfg_data[StepW-1:0];
        CFG_WINDOW:  retrig_window      <= cfg_data[WinW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      gate_level    <= 1'b0;
      pulse_pending <= 1'b0;
      ticks         <= TickMax;
      pitch_code    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        held_count    <= held_count_next;
        gate_level    <= gate_level_next;
        pulse_pending <= pulse_pending_next;
        ticks         <= ticks_next;
      end
      if (out_load) begin
        pitch_code    <= pitch_new;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Word payload held from acceptance through the pitch steps.
  always_ff @(posedge clk) begin
    if (acc) begin
      offset_q <= offset;
      use_top  <= use_top_next;
      do_pitch <= do_pitch_next;
    end
    if (state == ST_SEL) begin
      pitch_src <= use_top ? pick_chain[STACK_DEPTH] : offset_q;
    end
    if (out_load) begin
      out_word <= {pitch_new, gate_level};
    end
  end

  assign m_axis_tdata = OutDataW'(out_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        // No word is taken while reset is held.
        s_axis_tready = !rst;
        if (s_axis_tvalid) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The fill count never passes the number of cells.
  `MCVG_ASSERT_NOW(a_count_bound, 1'b1, held_count <= CountW'(STACK_DEPTH), "stack count overflow")
  // Only one word is in flight at a time.
  `MCVG_ASSERT_NEXT(a_one_word, acc, !s_axis_tready, "input taken while a word is in flight")
  // A retrigger note-on restarts the window timer.
  `MCVG_ASSERT_NEXT(a_timer_restart, acc && is_on && trigger_mode, ticks == '0, "timer not restarted")
  // A pending pulse only starts with the gate low.
  `MCVG_ASSERT_NOW(a_pulse_low, $rose(pulse_pending), !gate_level, "pulse pending with gate high")
  // Loading the output register always presents a word.
  `MCVG_ASSERT_NEXT(a_out_valid, out_load, m_axis_tvalid, "output word not presented")

endmodule

`default_nettype wire

// File: tb/mono_cv_gate_note_priority_top_tb.sv
// Self-checking testbench for the last-note priority CV/gate converter.
module mono_cv_gate_note_priority_top_tb;
  import mcvg_pkg::*;

  // The converter answers every input word with exactly one output word that
  // carries the gate level and pitch code standing after it. Each accepted
  // input word is run through a behavioural copy of the voice (held-note stack,
  // gate, pitch, retrigger timer) and the levels it should report are queued.
  // Each output word taken from the block is then checked against the oldest
  // queued levels.
  //
  // The run opens with a short directed table: reset levels, range edges,
  // repeated and stale notes, empty-stack releases, the spare operation code
  // and one retrigger pulse. Where the answer is obvious the table carries it
  // and the row is checked against that value; other rows use the predictor.
  // Randomised phases follow, each with its own register settings and its own
  // idling pattern. Inside a phase the stimulus is mostly musical: chords,
  // releases of notes that are really held, runs of ticks long enough to open
  // the retrigger window, and floods that overfill the stack. Some noise with
  // arbitrary codes and notes is mixed in.

  localparam int StackDepth = StackDepthDefault;
  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 40;
  localparam int SqueezeCycles = 400;
  localparam int FloodLength = StackDepth + 2;
  localparam logic [OpW-1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic              gate;
    logic [PitchW-1:0] pitch;
  } level_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cfg_idx_t          reg_idx;
    logic [CfgDataW-1:0] reg_val;
    logic [OpW-1:0]    op;
    logic [NoteW-1:0]  note;
    logic              typed;
    level_t            want;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic [InDataW-1:0]  in_data = '0;
  logic [InUserW-1:0]  in_user = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  wire                 in_ready;
  wire                 out_valid;
  wire [OutDataW-1:0]  out_data;

  // Register copies held by the predictor.
  logic [NoteW-1:0] cfg_lo;
  logic [HighW-1:0] cfg_hi;
  logic             cfg_retrig;
  logic [StepW-1:0] cfg_steps;
  logic [WinW-1:0]  cfg_win;

  // Voice state held by the predictor. Offsets are stored, not note numbers,
  // so a later change of the lowest note leaves the stack untouched.
  logic [NoteW-1:0]  held [StackDepth];
  int                held_n;
  logic              gate_now;
  logic [PitchW-1:0] pitch_now;
  logic              pulse_wait;
  logic [TickW-1:0]  tick_age;

  level_t due_levels[$];
  int     errors = 0;
  int     words_sent = 0;

  // Idling percentages for the current phase, and the one long receiver
  // hold-off used to back the block up into its input.
  int snd_pct = 0;
  int rcv_pct = 0;
  bit squeeze_req = 1'b0;
  bit squeezed = 1'b0;
  int hold_left = 0;

  mono_cv_gate_note_priority_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_user),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pitch code for a note offset: offset times a Q8.8 step, rounded half up, saturated.
  function automatic logic [PitchW-1:0] dac_code(input logic [NoteW-1:0] ofs);
    int unsigned scaled;
    scaled = (32'(ofs) * 32'(cfg_steps) + 32'd128) >> FracBits;
    return (scaled > 32'(PitchMax)) ? PitchMax : PitchW'(scaled);
  endfunction

  // A note inside the accepted range, or any note when the range is empty.
  function automatic logic [NoteW-1:0] chord_note();
    if (cfg_hi > cfg_lo)
      return NoteW'(int'(cfg_lo) + $urandom_range(int'(cfg_hi) - int'(cfg_lo) - 1));
    return NoteW'($urandom_range(127));
  endfunction

  task automatic drop_held(input logic [NoteW-1:0] ofs);
    int w;
    w = 0;
    for (int r = 0; r < held_n; r++) begin
      if (held[r] != ofs) begin
        held[w] = held[r];
        w++;
      end
    end
    held_n = w;
  endtask

  // Advances the predicted voice by one accepted word.
  task automatic voice_step(input logic [OpW-1:0] op, input logic [NoteW-1:0] note);
    logic             in_span;
    logic [NoteW-1:0] ofs;
    logic             had_notes;
    in_span = (note >= cfg_lo) && ({1'b0, note} < cfg_hi);
    ofs = note - cfg_lo;
    if (op == OP_NOTE_ON && in_span) begin
      had_notes = (held_n != 0);
      pitch_now = dac_code(ofs);
      drop_held(ofs);
      // A full stack loses its oldest note to make room.
      if (held_n >= StackDepth) begin
        for (int i = 1; i < StackDepth; i++)
          held[i-1] = held[i];
        held_n = StackDepth - 1;
      end
      held[held_n] = ofs;
      held_n++;
      if (!cfg_retrig) begin
        gate_now = 1'b1;
      end else begin
        if (had_notes && tick_age > cfg_win) begin
          pulse_wait = 1'b1;
          gate_now = 1'b0;
        end else begin
          gate_now = 1'b1;
        end
        tick_age = '0;
      end
    end else if (op == OP_NOTE_OFF && in_span) begin
      if (held_n != 0)
        drop_held(ofs);
      if (held_n != 0) begin
        pitch_now = dac_code(held[held_n-1]);
      end else begin
        pulse_wait = 1'b0;
        gate_now = 1'b0;
      end
    end else if (op == OP_TICK) begin
      if (tick_age != TickMax)
        tick_age++;
      if (pulse_wait && tick_age > cfg_win) begin
        gate_now = 1'b1;
        pulse_wait = 1'b0;
      end
    end
  endtask

  // Offers one word, waits for it to be taken, and queues the levels it
  // should produce: the typed ones for table rows that carry them.
  task automatic offer(input logic [OpW-1:0] op, input logic [NoteW-1:0] note,
                       input bit typed = 1'b0, input level_t want = '0);
    level_t predicted;
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_user <= op;
    in_data <= InDataW'(note);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    voice_step(op, note);
    predicted.gate = gate_now;
    predicted.pitch = pitch_now;
    due_levels.insert(due_levels.size(), typed ? want : predicted);
    words_sent++;
  endtask

  // Withdraws the input and waits until every queued word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_LOWEST:  cfg_lo = val[NoteW-1:0];
      CFG_HIGHEST: cfg_hi = val[HighW-1:0];
      CFG_MODE:    cfg_retrig = val[0];
      CFG_STEPS:   cfg_steps = val[StepW-1:0];
      CFG_WINDOW:  cfg_win = val[WinW-1:0];
      default: ;
    endcase
  endtask

  // One randomised phase: a fresh register set, an idling pattern, then
  // bursts of words until about n have been accepted. The held stack is
  // carried over from the previous phase on purpose.
  task automatic run_phase(input logic [NoteW-1:0] lo, input logic [HighW-1:0] hi,
                           input logic mode, input logic [StepW-1:0] steps,
                           input logic [WinW-1:0] win, input int snd, input int rcv,
                           input int n, input bit squeeze = 1'b0);
    int stop;
    int span;
    int pick;
    int start;
    settle();
    set_reg(CFG_LOWEST, CfgDataW'(lo));
    set_reg(CFG_HIGHEST, CfgDataW'(hi));
    set_reg(CFG_MODE, CfgDataW'(mode));
    set_reg(CFG_STEPS, steps);
    set_reg(CFG_WINDOW, win);
    snd_pct = snd;
    rcv_pct = rcv;
    if (squeeze)
      squeeze_req = 1'b1;
    span = (cfg_hi > cfg_lo) ? int'(cfg_hi) - int'(cfg_lo) : 0;
    stop = words_sent + n;
    while (words_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 4)) offer(OP_NOTE_ON, chord_note());
      end else if (pick < 60) begin
        // Release notes that are really held where there are any.
        repeat ($urandom_range(1, 3))
          offer(OP_NOTE_OFF, held_n != 0 ?
                NoteW'(held[$urandom_range(held_n - 1)] + cfg_lo) : chord_note());
      end else if (pick < 85) begin
        // Short windows get runs long enough to let a retrigger pulse end.
        repeat (cfg_retrig && cfg_win <= 40 ? $urandom_range(1, int'(cfg_win) + 3)
                                            : $urandom_range(1, 6))
          offer(OP_TICK, NoteW'($urandom_range(127)));
      end else if (pick < 95 || span == 0) begin
        repeat ($urandom_range(1, 3))
          offer(OpW'($urandom_range(3)), NoteW'($urandom_range(127)));
      end else begin
        // Walk up the range to push more notes than the stack can hold.
        start = $urandom_range(span - 1);
        for (int k = 0; k < FloodLength; k++)
          offer(OP_NOTE_ON, NoteW'(int'(cfg_lo) + (start + k) % span));
      end
    end
  endtask

  // Output side: random stalls, one long hold-off on request, and the check
  // of every word taken against the oldest queued levels.
  always @(posedge clk) begin : sink
    level_t want;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeezed) begin
      out_ready <= 1'b0;
      hold_left <= SqueezeCycles;
      squeezed <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_pct);
    end
    if (!rst && out_valid && out_ready) begin
      if (due_levels.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got gate %0d pitch %0d",
                 $time, out_data[0], out_data[PitchW:1]);
        errors++;
      end else begin
        want = due_levels.pop_front();
        if (out_data[0] !== want.gate) begin
          $display("%0t: gate mismatch, expected %0d, got %0d",
                   $time, want.gate, out_data[0]);
          errors++;
        end
        if (out_data[PitchW:1] !== want.pitch) begin
          $display("%0t: pitch mismatch, expected %0d, got %0d",
                   $time, want.pitch, out_data[PitchW:1]);
          errors++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mono_cv_gate_note_priority_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    step_row_t plan [23];

    cfg_lo = LowestReset;
    cfg_hi = HighestReset;
    cfg_retrig = ModeReset;
    cfg_steps = StepsReset;
    cfg_win = WindowReset;
    held_n = 0;
    gate_now = 1'b0;
    pitch_now = '0;
    pulse_wait = 1'b0;
    tick_age = TickMax;

    // Directed rows run on the reset settings (notes 36 to 90, legato) until
    // the two register rows switch to retrigger with a window of two ticks.
    plan = '{
      // Levels straight after reset; the timer is already saturated.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b1, '{1'b0, 12'd0}},
      // Release with nothing held, then the spare operation code.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_OFF, 7'd60,  1'b1, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OpSpare,     7'd127, 1'b1, '{1'b0, 12'd0}},
      // Lowest note maps to pitch zero; notes just outside the range are ignored.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd36,  1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd35,  1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd91,  1'b1, '{1'b1, 12'd0}},
      // Highest note in range, a neighbour, then the highest one pressed again.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd90,  1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd37,  1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd90,  1'b0, '{1'b0, 12'd0}},
      // Release of an older note, then of a note that is not held.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_OFF, 7'd37,  1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_OFF, 7'd50,  1'b0, '{1'b0, 12'd0}},
      // Fall back to the lowest note, then let go of everything.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_OFF, 7'd90,  1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_OFF, 7'd36,  1'b1, '{1'b0, 12'd0}},
      '{ROW_REG,  CFG_MODE,   16'd1, OP_TICK,     7'd0,   1'b0, '{1'b0, 12'd0}},
      '{ROW_REG,  CFG_WINDOW, 16'd2, OP_TICK,     7'd0,   1'b0, '{1'b0, 12'd0}},
      // First note onto an empty stack opens the gate without a pulse.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd36,  1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b1, '{1'b1, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b1, '{1'b1, 12'd0}},
      // Window has elapsed with a note held: the gate drops and rises again on the third tick.
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_NOTE_ON,  7'd40,  1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b0, '{1'b0, 12'd0}},
      '{ROW_WORD, CFG_LOWEST, 16'd0, OP_TICK,     7'd0,   1'b0, '{1'b0, 12'd0}}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer(plan[i].op, plan[i].note, plan[i].typed, plan[i].want);
      end
    end
    // Releasing both notes ends the pulse test with the gate low.
    offer(OP_NOTE_OFF, 7'd40, 1'b1, '{1'b1, 12'd0});
    offer(OP_NOTE_OFF, 7'd36, 1'b1, '{1'b0, 12'd0});

    // Reset settings, no idling.
    run_phase(7'd36, 8'd91, 1'b0, 16'd18990, 16'd10000, 0, 0, 250);
    // Full range, steepest scale so most notes saturate, shortest window.
    run_phase(7'd0, 8'd128, 1'b1, 16'hFFFF, 16'd1, 51, 0, 250);
    // Topmost note alone, flat scale.
    run_phase(7'd127, 8'd128, 1'b1, 16'd0, 16'd3, 0, 51, 120);
    // Empty range: every note is ignored and only ticks act; longest window.
    run_phase(7'd0, 8'd0, 1'b0, 16'd1, 16'hFFFF, 6, 6, 40);
    run_phase(NoteW'($urandom_range(100)), HighW'($urandom_range(101, 128)), 1'b1,
              StepW'($urandom), WinW'($urandom_range(1, 12)), 6, 6, 300);
    // The receiver holds off for a long stretch while words keep coming.
    run_phase(7'd20, 8'd40, 1'b1, StepW'($urandom), 16'hFFFF, 0, 0, 200, 1'b1);
    run_phase(NoteW'($urandom_range(60, 100)), HighW'($urandom_range(100, 128)), 1'b1,
              StepW'($urandom), WinW'($urandom_range(1, 40)), 51, 0, 300);
    run_phase(NoteW'($urandom_range(30)), HighW'($urandom_range(31, 60)), 1'b0,
              StepW'($urandom), WinW'($urandom), 0, 51, 300);

    settle();
    // Anything arriving now has no queued levels and is flagged by the sink.
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0)
      $display("mono_cv_gate_note_priority_top regression: pass");
    else
      $display("mono_cv_gate_note_priority_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/mcvg_pkg.sv
src/mcvg_cell.sv
src/mcvg_pitch.sv
src/mono_cv_gate_note_priority_top.sv
tb/mono_cv_gate_note_priority_top_tb.sv
